// ===== hdl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// Delay timer queue package
// Shared sizes, codes and the command format passed from front to back.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 4;

    localparam int IDX_W      = $clog2(QUEUE_DEPTH);
    localparam int OCC_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int TICK_W     = 8;
    localparam int TAG_W      = 8;
    localparam int ID_PORT_W  = 4;
    localparam int KIND_W     = 2;

    localparam int CQ_DEPTH   = 2;
    localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W   = $clog2(CQ_DEPTH + 1);

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_REQ  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_FULL   = 2'd1,
        KIND_WAKE   = 2'd2
    } t_kind;

    typedef struct packed {
        logic                is_req;
        logic [TICK_W-1:0]   delay;
        logic [ID_BITS-1:0]  id;
        logic [TAG_W-1:0]    tag;
    } t_cmd;

endpackage

// ===== hdl/delay_timer_queue.sv =====
// ----------------------------------------------------------------------------
// Delay timer queue
// Arrival-ordered list of countdown timers with wakeup reporting.
// ----------------------------------------------------------------------------
// A request passes the command queue, then the output register; one item each
// cycle while no output stall or tick sweep holds the back end. A tick walks
// every stored entry, then flushes if any expired; output stalls lengthen it.
// The command queue holds two transfers; the output register frees the back end.
// Synchronous active-low reset empties the list, the command queue and output.
// Stored entries are not cleared by reset.
module delay_timer_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [dtq_pkg::TICK_W-1:0]    i_delay_ticks,
    input  logic [dtq_pkg::ID_PORT_W-1:0] i_requester,
    input  logic [dtq_pkg::TAG_W-1:0]     i_envelope_tag,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dtq_pkg::KIND_W-1:0]    o_kind,
    output logic [dtq_pkg::ID_PORT_W-1:0] o_woken_id,
    output logic [dtq_pkg::TAG_W-1:0]     o_tag_out,
    output logic                          o_last
);

    logic           cmd_valid;
    logic           cmd_pop;
    dtq_pkg::t_cmd  cmd;

    dtq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_delay_ticks  (i_delay_ticks),
        .i_requester    (i_requester),
        .i_envelope_tag (i_envelope_tag),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    dtq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_woken_id  (o_woken_id),
        .o_tag_out   (o_tag_out),
        .o_last      (o_last)
    );

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != dtq_pkg::KIND_WAKE) |-> o_last)
        else $error("request answer without last marker");

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

endmodule

// ===== hdl/dtq_front.sv =====
// ----------------------------------------------------------------------------
// Delay timer queue front end
// Accepts input transfers, decodes them into commands and buffers them in a
// short command queue for the back end.
// ----------------------------------------------------------------------------
module dtq_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_func,
    input  logic [dtq_pkg::TICK_W-1:0]   i_delay_ticks,
    input  logic [dtq_pkg::ID_PORT_W-1:0] i_requester,
    input  logic [dtq_pkg::TAG_W-1:0]    i_envelope_tag,
    output logic                         o_cmd_valid,
    output dtq_pkg::t_cmd                o_cmd,
    input  logic                         i_cmd_pop
);

    dtq_pkg::t_cmd                   r_q [dtq_pkg::CQ_DEPTH];
    logic [dtq_pkg::CQ_PTR_W-1:0]    r_wp, n_wp;
    logic [dtq_pkg::CQ_PTR_W-1:0]    r_rp, n_rp;
    logic [dtq_pkg::CQ_CNT_W-1:0]    r_cnt, n_cnt;
    logic                            push;
    logic                            pop;
    dtq_pkg::t_cmd                   in_cmd;

    assign o_stall     = (r_cnt == dtq_pkg::CQ_CNT_W'(dtq_pkg::CQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && !o_stall;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        in_cmd.is_req = (i_func == dtq_pkg::FUNC_REQ);
        in_cmd.delay  = i_delay_ticks;
        in_cmd.id     = dtq_pkg::ID_BITS'(i_requester);
        in_cmd.tag    = i_envelope_tag;
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == dtq_pkg::CQ_PTR_W'(dtq_pkg::CQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == dtq_pkg::CQ_PTR_W'(dtq_pkg::CQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_cmd;
        end
    end

endmodule

// ===== hdl/dtq_back.sv =====
// ----------------------------------------------------------------------------
// Delay timer queue back end
// Holds the timer list, appends requests or reports it full, sweeps the list on each tick to
// count down, compact survivors and emit wakeups through an output register.
// ----------------------------------------------------------------------------
module dtq_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  dtq_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dtq_pkg::KIND_W-1:0]    o_kind,
    output logic [dtq_pkg::ID_PORT_W-1:0] o_woken_id,
    output logic [dtq_pkg::TAG_W-1:0]     o_tag_out,
    output logic                          o_last
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [dtq_pkg::OCC_W-1:0]       r_occ, n_occ;
    logic [dtq_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [dtq_pkg::OCC_W-1:0]       r_keep, n_keep;
    logic                            r_hold_valid, n_hold_valid;
    logic [dtq_pkg::ID_BITS-1:0]     r_hold_id, n_hold_id;
    logic [dtq_pkg::TAG_W-1:0]       r_hold_tag, n_hold_tag;

    logic [dtq_pkg::TICK_W-1:0]      r_rem [dtq_pkg::QUEUE_DEPTH];
    logic [dtq_pkg::ID_BITS-1:0]     r_own [dtq_pkg::QUEUE_DEPTH];
    logic [dtq_pkg::TAG_W-1:0]       r_etag [dtq_pkg::QUEUE_DEPTH];

    logic                            r_out_valid;
    dtq_pkg::t_kind                  r_kind;
    logic [dtq_pkg::ID_PORT_W-1:0]   r_id;
    logic [dtq_pkg::TAG_W-1:0]       r_tag;
    logic                            r_last;

    logic                            out_free;
    logic                            we;
    logic [dtq_pkg::IDX_W-1:0]       waddr;
    logic [dtq_pkg::TICK_W-1:0]      wrem;
    logic [dtq_pkg::ID_BITS-1:0]     wown;
    logic [dtq_pkg::TAG_W-1:0]       wtag;
    logic                            emit;
    dtq_pkg::t_kind                  e_kind;
    logic [dtq_pkg::ID_BITS-1:0]     e_id;
    logic [dtq_pkg::TAG_W-1:0]       e_tag;
    logic                            e_last;
    logic [dtq_pkg::TICK_W-1:0]      dec;
    logic                            expire;
    logic                            last_entry;
    logic                            is_full;

    assign out_free   = !r_out_valid || !i_stall;
    assign dec        = r_rem[r_idx] - 1'b1;
    assign expire     = (dec == '0);
    assign last_entry = ((dtq_pkg::OCC_W'(r_idx) + 1'b1) == r_occ);
    assign is_full    = (r_occ == dtq_pkg::OCC_W'(dtq_pkg::QUEUE_DEPTH));

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_idx        = r_idx;
        n_keep       = r_keep;
        n_hold_valid = r_hold_valid;
        n_hold_id    = r_hold_id;
        n_hold_tag   = r_hold_tag;
        o_cmd_pop    = 1'b0;
        we           = 1'b0;
        waddr        = r_occ[dtq_pkg::IDX_W-1:0];
        wrem         = i_cmd.delay;
        wown         = i_cmd.id;
        wtag         = i_cmd.tag;
        emit         = 1'b0;
        e_kind       = dtq_pkg::KIND_ACCEPT;
        e_id         = i_cmd.id;
        e_tag        = i_cmd.tag;
        e_last       = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_req) begin
                        emit = 1'b1;
                        if (is_full) begin
                            e_kind = dtq_pkg::KIND_FULL;
                        end else begin
                            we    = 1'b1;
                            n_occ = r_occ + 1'b1;
                        end
                    end else if (r_occ != '0) begin
                        n_idx        = '0;
                        n_keep       = '0;
                        n_hold_valid = 1'b0;
                        n_state      = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                if (!(expire && r_hold_valid && !out_free)) begin
                    if (expire) begin
                        if (r_hold_valid) begin
                            emit   = 1'b1;
                            e_kind = dtq_pkg::KIND_WAKE;
                            e_id   = r_hold_id;
                            e_tag  = r_hold_tag;
                            e_last = 1'b0;
                        end
                        n_hold_valid = 1'b1;
                        n_hold_id    = r_own[r_idx];
                        n_hold_tag   = r_etag[r_idx];
                    end else begin
                        we     = 1'b1;
                        waddr  = r_keep[dtq_pkg::IDX_W-1:0];
                        wrem   = dec;
                        wown   = r_own[r_idx];
                        wtag   = r_etag[r_idx];
                        n_keep = r_keep + 1'b1;
                    end
                    if (last_entry) begin
                        n_occ   = n_keep;
                        n_state = n_hold_valid ? ST_FLUSH : ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    emit         = 1'b1;
                    e_kind       = dtq_pkg::KIND_WAKE;
                    e_id         = r_hold_id;
                    e_tag        = r_hold_tag;
                    e_last       = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_occ        <= '0;
            r_idx        <= '0;
            r_keep       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_occ        <= n_occ;
            r_idx        <= n_idx;
            r_keep       <= n_keep;
            r_hold_valid <= n_hold_valid;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_id  <= n_hold_id;
        r_hold_tag <= n_hold_tag;
        if (emit) begin
            r_kind <= e_kind;
            r_id   <= dtq_pkg::ID_PORT_W'(e_id);
            r_tag  <= e_tag;
            r_last <= e_last;
        end
        if (we) begin
            r_rem[waddr]  <= wrem;
            r_own[waddr]  <= wown;
            r_etag[waddr] <= wtag;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_kind;
    assign o_woken_id = r_id;
    assign o_tag_out  = r_tag;
    assign o_last     = r_last;

endmodule
